// File: hw/rtl/pvq_pkg.sv
// Shared types and constants for the persistent versioned queue.
// Holds action and status codes plus the controller/datapath command and status words.
// No dependencies.
package pvq_pkg;

   localparam int ACTION_W = 2;
   localparam int VNUM_W   = 8;
   localparam int STATUS_W = 2;

   typedef logic [ACTION_W-1:0] pvq_action_type;
   typedef logic [STATUS_W-1:0] pvq_status_type;

   localparam pvq_action_type ACT_ENQ  = 2'd0;
   localparam pvq_action_type ACT_DEQ  = 2'd1;
   localparam pvq_action_type ACT_READ = 2'd2;

   localparam pvq_status_type ST_OK    = 2'd0;
   localparam pvq_status_type ST_EMPTY = 2'd1;
   localparam pvq_status_type ST_RANGE = 2'd2;
   localparam pvq_status_type ST_FULL  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           cmd_load;     // capture the accepted request word
      logic           do_enq;       // append element, record version
      logic           do_deq;       // read head element, advance head, record version
      logic           tbl_rd;       // read the version table entry
      logic           str_rd_first; // start streaming at the version head
      logic           str_rd_next;  // advance the stream pointer
      logic           emit;         // load the response register
      pvq_status_type emit_status;
      logic           emit_elem;    // response data comes from the element store
      logic           emit_last;
   } pvq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      pvq_action_type action;
      logic           q_empty;
      logic           elem_full;
      logic           ver_full;
      logic           vnum_bad;
      logic           ver_empty;
      logic           stream_last;
      logic           out_free;
   } pvq_sts_type;

endpackage

// File: hw/rtl/pvq_ctrl.sv
// Controller state machine for the persistent versioned queue.
// Depends on pvq_pkg for the command and status words.
module pvq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pvq_pkg::pvq_sts_type sts,
   output pvq_pkg::pvq_cmd_type cmd
);
   import pvq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DEQ    = 3'd2;
   localparam logic [2:0] S_VLOAD  = 3'd3;
   localparam logic [2:0] S_STREAM = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cmd_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.action)
               ACT_ENQ: begin
                  if (sts.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     if (sts.elem_full || sts.ver_full) begin
                        cmd.emit_status = ST_FULL;
                     end else begin
                        cmd.do_enq      = 1'b1;
                        cmd.emit_status = ST_OK;
                     end
                     state_in = S_IDLE;
                  end
               end
               ACT_DEQ: begin
                  if (sts.q_empty || sts.ver_full) begin
                     if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = sts.q_empty ? ST_EMPTY : ST_FULL;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.do_deq = 1'b1;
                     state_in   = S_DEQ;
                  end
               end
               ACT_READ: begin
                  if (sts.vnum_bad) begin
                     if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = ST_RANGE;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.tbl_rd = 1'b1;
                     state_in   = S_VLOAD;
                  end
               end
               default: begin
                  // The unused action code produces nothing.
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DEQ: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_elem   = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
            end
         end
         S_VLOAD: begin
            if (sts.ver_empty) begin
               if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = ST_EMPTY;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.str_rd_first = 1'b1;
               state_in         = S_STREAM;
            end
         end
         S_STREAM: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_elem   = 1'b1;
               cmd.emit_last   = sts.stream_last;
               cmd.emit_status = ST_OK;
               if (sts.stream_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.str_rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/pvq_dp.sv
// Datapath of the persistent versioned queue: element store, version table,
// counters, stream pointer and response register. Depends on pvq_pkg.
module pvq_dp #(
   parameter int ELEMENT_DEPTH = 64,
   parameter int VERSION_DEPTH = 128,
   parameter int DATA_WIDTH    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pvq_pkg::pvq_action_type       req_action,
   input  logic signed [DATA_WIDTH-1:0]  req_value,
   input  logic [pvq_pkg::VNUM_W-1:0]    req_version_number,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [DATA_WIDTH-1:0]  rsp_data,
   output pvq_pkg::pvq_status_type       rsp_status,
   output logic                          rsp_last,
   input  pvq_pkg::pvq_cmd_type          cmd,
   output pvq_pkg::pvq_sts_type          sts
);
   import pvq_pkg::*;

   localparam int EIW  = $clog2(ELEMENT_DEPTH);
   localparam int ECW  = $clog2(ELEMENT_DEPTH + 1);
   localparam int VIW  = $clog2(VERSION_DEPTH);
   localparam int VCW  = $clog2(VERSION_DEPTH + 1);
   localparam int CMPW = (VCW > VNUM_W) ? VCW : VNUM_W;

   // Element store and version table (head and end packed per entry).
   logic signed [DATA_WIDTH-1:0] elem_mem [ELEMENT_DEPTH];
   logic [2*ECW-1:0]             vtab_mem [VERSION_DEPTH];

   logic signed [DATA_WIDTH-1:0] elem_rd_ff;
   logic [2*ECW-1:0]             vtab_rd_ff;

   pvq_action_type               act_ff;
   logic signed [DATA_WIDTH-1:0] value_ff;
   logic [VNUM_W-1:0]            vnum_ff;

   logic [ECW-1:0] wcount_ff, wcount_in;
   logic [ECW-1:0] head_ff, head_in;
   logic [VCW-1:0] vcount_ff, vcount_in;
   logic [ECW-1:0] ptr_ff, ptr_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_data_ff;
   pvq_status_type               rsp_status_ff;
   logic                         rsp_last_ff;

   logic [ECW-1:0]  ver_h, ver_e;
   logic [CMPW-1:0] vnum_ext, vcount_ext;
   logic [VIW-1:0]  vtab_rd_addr;
   logic            vtab_we;
   logic [2*ECW-1:0] vtab_wdata;
   logic            elem_re;
   logic [EIW-1:0]  elem_rd_addr;

   assign ver_h = vtab_rd_ff[2*ECW-1:ECW];
   assign ver_e = vtab_rd_ff[ECW-1:0];

   assign vnum_ext     = CMPW'(vnum_ff);
   assign vcount_ext   = CMPW'(vcount_ff);
   assign vtab_rd_addr = VIW'(vnum_ext - CMPW'(1));

   // Status to the controller.
   assign sts.action      = act_ff;
   assign sts.q_empty     = (head_ff == wcount_ff);
   assign sts.elem_full   = (wcount_ff == ECW'(ELEMENT_DEPTH));
   assign sts.ver_full    = (vcount_ff == VCW'(VERSION_DEPTH));
   assign sts.vnum_bad    = (vnum_ff == '0) || (vnum_ext > vcount_ext);
   assign sts.ver_empty   = (ver_h >= ver_e);
   assign sts.stream_last = ((ptr_ff + ECW'(1)) == ver_e);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wcount_in = wcount_ff;
      head_in   = head_ff;
      vcount_in = vcount_ff;
      ptr_in    = ptr_ff;
      if (cmd.do_enq) begin
         wcount_in = wcount_ff + ECW'(1);
         vcount_in = vcount_ff + VCW'(1);
      end
      if (cmd.do_deq) begin
         head_in   = head_ff + ECW'(1);
         vcount_in = vcount_ff + VCW'(1);
      end
      if (cmd.str_rd_first) begin
         ptr_in = ver_h;
      end else if (cmd.str_rd_next) begin
         ptr_in = ptr_ff + ECW'(1);
      end
   end

   // The new version records the counters as they stand after this operation.
   assign vtab_we    = cmd.do_enq || cmd.do_deq;
   assign vtab_wdata = {head_in, wcount_in};

   assign elem_re      = cmd.do_deq || cmd.str_rd_first || cmd.str_rd_next;
   assign elem_rd_addr = cmd.do_deq ? EIW'(head_ff) : EIW'(ptr_in);

   always_ff @(posedge clock) begin
      if (cmd.do_enq) begin
         elem_mem[EIW'(wcount_ff)] <= value_ff;
      end
      if (elem_re) begin
         elem_rd_ff <= elem_mem[elem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (vtab_we) begin
         vtab_mem[VIW'(vcount_ff)] <= vtab_wdata;
      end
      if (cmd.tbl_rd) begin
         vtab_rd_ff <= vtab_mem[vtab_rd_addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff    <= '0;
         head_ff      <= '0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wcount_ff    <= wcount_in;
         head_ff      <= head_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.cmd_load) begin
         act_ff   <= req_action;
         value_ff <= req_value;
         vnum_ff  <= req_version_number;
      end
      if (cmd.emit) begin
         rsp_data_ff   <= cmd.emit_elem ? elem_rd_ff : '0;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: hw/rtl/persistent_versioned_queue_unit.sv
// Persistent versioned queue: top level joining the controller and the datapath.
// An enqueue or a request rejected at decode loads its response word in S_DECODE, a
// dequeue or an empty-version read in S_DEQ or S_VLOAD (registered store or table read), and a
// version read its first word in S_STREAM, then one word per cycle while rsp_stall does not hold it.
// The next request is accepted the cycle after the last response word is loaded.
// Synchronous active-high reset empties the queue and the version history; stores need no clear.
module persistent_versioned_queue_unit #(
   parameter int ELEMENT_DEPTH = 64,
   parameter int VERSION_DEPTH = 128,
   parameter int DATA_WIDTH    = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  pvq_pkg::pvq_action_type      req_action,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic [pvq_pkg::VNUM_W-1:0]   req_version_number,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_data,
   output pvq_pkg::pvq_status_type      rsp_status,
   output logic                         rsp_last
);
   import pvq_pkg::*;

   // The controller sequences each request word through its few states and
   // issues one-cycle commands; the datapath owns all storage. Elements are
   // appended to a store that is never overwritten, and every successful
   // enqueue or dequeue records the head and end indices as a new version,
   // so any past version is the contiguous run [head, end) of the store.
   pvq_cmd_type cmd;
   pvq_sts_type sts;

   // The control FSM stalls the request side whenever a word is in flight.
   pvq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the response register, which lets a finished word wait
   // for the consumer while the controller holds its state.
   pvq_dp #(
      .ELEMENT_DEPTH (ELEMENT_DEPTH),
      .VERSION_DEPTH (VERSION_DEPTH),
      .DATA_WIDTH    (DATA_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_action),
      .req_value          (req_value),
      .req_version_number (req_version_number),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_data           (rsp_data),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule
